>>> hdl/cau_pkg.sv
// shared types, action codes and saturation helpers for the complex arithmetic unit
// no dependencies
`default_nettype none
package cau_pkg;

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_SUB = 2'd1;
   localparam logic [1:0] ACT_MUL = 2'd2;
   localparam logic [1:0] ACT_DIV = 2'd3;

   localparam int DEN_W = 64;
   localparam int QUO_W = 33;
   localparam int REM_W = DEN_W + QUO_W;
   localparam int CELLS = QUO_W;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             pre_ovf;
   } lane_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [DEN_W-1:0] den;
      lane_type         re;
      lane_type         im;
      logic [31:0]      fast_re;
      logic [31:0]      fast_im;
      logic             fast_ovf;
      logic             div_zero;
   } stage_type;

   // {ovf, value}
   function automatic logic [32:0] sat32(input logic signed [64:0] v);
      logic [33:0] hi;
      hi = v[64:31];
      if ((&hi) || !(|hi)) begin
         sat32 = {1'b0, v[31:0]};
      end else if (v[64]) begin
         sat32 = {1'b1, 32'h8000_0000};
      end else begin
         sat32 = {1'b1, 32'h7fff_ffff};
      end
   endfunction

   function automatic logic [32:0] quo_sat(input lane_type l);
      logic [QUO_W-1:0] negq;
      negq = ~l.quo + 1'b1;
      if (l.pre_ovf) begin
         quo_sat = {1'b1, (l.neg ? 32'h8000_0000 : 32'h7fff_ffff)};
      end else if (l.neg) begin
         if (l.quo > 33'h0_8000_0000) begin
            quo_sat = {1'b1, 32'h8000_0000};
         end else begin
            quo_sat = {1'b0, negq[31:0]};
         end
      end else if (l.quo[32] || l.quo[31]) begin
         quo_sat = {1'b1, 32'h7fff_ffff};
      end else begin
         quo_sat = {1'b0, l.quo[31:0]};
      end
   endfunction

endpackage
`default_nettype wire

>>> hdl/cau_front.sv
// operand capture, products, sums and divider setup ahead of the divider chain
// depends on cau_pkg
`default_nettype none
module cau_front #(
   parameter int FRAC_BITS = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 en,
   input  wire                 in_valid,
   input  wire  [1:0]          in_action,
   input  wire  signed [31:0]  in_a,
   input  wire  signed [31:0]  in_b,
   input  wire  signed [31:0]  in_c,
   input  wire  signed [31:0]  in_d,
   output logic                out_valid,
   output cau_pkg::stage_type  out_stage
);

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [1:0]         act1_ff, act2_ff, act3_ff;
   logic signed [31:0] a1_ff, b1_ff, c1_ff, d1_ff;
   logic signed [63:0] pac_ff, pbd_ff, pbc_ff, pad_ff, pcc_ff, pdd_ff;
   logic signed [32:0] sr2_ff, si2_ff, sr2_in, si2_in;
   logic signed [64:0] fr3_ff, fi3_ff, nr3_ff, ni3_ff;
   logic signed [64:0] fr3_in, fi3_in, nr3_in, ni3_in;
   logic [63:0]        den3_ff, den3_in;
   cau_pkg::stage_type st4_ff, st4_in;

   logic signed [32:0] ax, bx, cx, dx;
   logic signed [64:0] xac, xbd, xbc, xad;
   logic signed [64:0] fr_sel, fi_sel;
   logic [32:0]        sat_re, sat_im;
   logic [64:0]        mag_re, mag_im;
   logic [cau_pkg::REM_W-1:0] den_top;

   always_comb begin
      ax = {a1_ff[31], a1_ff};
      bx = {b1_ff[31], b1_ff};
      cx = {c1_ff[31], c1_ff};
      dx = {d1_ff[31], d1_ff};
      sr2_in = (act1_ff == cau_pkg::ACT_ADD) ? ax + cx : ax - cx;
      si2_in = (act1_ff == cau_pkg::ACT_ADD) ? bx + dx : bx - dx;
   end

   always_comb begin
      xac = {pac_ff[63], pac_ff};
      xbd = {pbd_ff[63], pbd_ff};
      xbc = {pbc_ff[63], pbc_ff};
      xad = {pad_ff[63], pad_ff};
      if (act2_ff == cau_pkg::ACT_MUL) begin
         fr3_in = xac - xbd;
         fi3_in = xbc + xad;
      end else begin
         fr3_in = {{32{sr2_ff[32]}}, sr2_ff};
         fi3_in = {{32{si2_ff[32]}}, si2_ff};
      end
      nr3_in  = xac + xbd;
      ni3_in  = xbc - xad;
      den3_in = pcc_ff + pdd_ff;
   end

   always_comb begin
      if (act3_ff == cau_pkg::ACT_MUL) begin
         fr_sel = fr3_ff >>> FRAC_BITS;
         fi_sel = fi3_ff >>> FRAC_BITS;
      end else begin
         fr_sel = fr3_ff;
         fi_sel = fi3_ff;
      end
      sat_re = cau_pkg::sat32(fr_sel);
      sat_im = cau_pkg::sat32(fi_sel);
      mag_re = nr3_ff[64] ? -nr3_ff : nr3_ff;
      mag_im = ni3_ff[64] ? -ni3_ff : ni3_ff;
      den_top = {33'b0, den3_ff} << cau_pkg::QUO_W;
      st4_in.action     = act3_ff;
      st4_in.den        = den3_ff;
      st4_in.re.rem     = {33'b0, mag_re[63:0]} << FRAC_BITS;
      st4_in.im.rem     = {33'b0, mag_im[63:0]} << FRAC_BITS;
      st4_in.re.quo     = '0;
      st4_in.im.quo     = '0;
      st4_in.re.neg     = nr3_ff[64];
      st4_in.im.neg     = ni3_ff[64];
      st4_in.re.pre_ovf = st4_in.re.rem >= den_top;
      st4_in.im.pre_ovf = st4_in.im.rem >= den_top;
      st4_in.fast_re    = sat_re[31:0];
      st4_in.fast_im    = sat_im[31:0];
      st4_in.fast_ovf   = sat_re[32] | sat_im[32];
      st4_in.div_zero   = (act3_ff == cau_pkg::ACT_DIV) && (den3_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         act1_ff <= in_action;
         a1_ff   <= in_a;
         b1_ff   <= in_b;
         c1_ff   <= in_c;
         d1_ff   <= in_d;
         act2_ff <= act1_ff;
         pac_ff  <= a1_ff * c1_ff;
         pbd_ff  <= b1_ff * d1_ff;
         pbc_ff  <= b1_ff * c1_ff;
         pad_ff  <= a1_ff * d1_ff;
         pcc_ff  <= c1_ff * c1_ff;
         pdd_ff  <= d1_ff * d1_ff;
         sr2_ff  <= sr2_in;
         si2_ff  <= si2_in;
         act3_ff <= act2_ff;
         fr3_ff  <= fr3_in;
         fi3_ff  <= fi3_in;
         nr3_ff  <= nr3_in;
         ni3_ff  <= ni3_in;
         den3_ff <= den3_in;
         st4_ff  <= st4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_stage = st4_ff;

endmodule
`default_nettype wire

>>> hdl/cau_div_cell.sv
// one restoring division step for both result parts, one quotient bit per cell
// depends on cau_pkg
`default_nettype none
module cau_div_cell #(
   parameter int SHIFT = 0
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 en,
   input  wire                 in_valid,
   input  cau_pkg::stage_type  in_stage,
   output logic                out_valid,
   output cau_pkg::stage_type  out_stage
);

   logic                      valid_ff;
   cau_pkg::stage_type        stage_ff, stage_in;
   logic [cau_pkg::REM_W-1:0] dsh;

   function automatic cau_pkg::lane_type step(input cau_pkg::lane_type l,
                                              input logic [cau_pkg::REM_W-1:0] d);
      logic [cau_pkg::REM_W:0] trial;
      cau_pkg::lane_type       r;
      trial = {1'b0, l.rem} - {1'b0, d};
      r = l;
      if (!trial[cau_pkg::REM_W]) begin
         r.rem = trial[cau_pkg::REM_W-1:0];
      end
      r.quo = {l.quo[cau_pkg::QUO_W-2:0], !trial[cau_pkg::REM_W]};
      step = r;
   endfunction

   always_comb begin
      dsh = {33'b0, in_stage.den} << SHIFT;
      stage_in    = in_stage;
      stage_in.re = step(in_stage.re, dsh);
      stage_in.im = step(in_stage.im, dsh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule
`default_nettype wire

>>> hdl/cau_back.sv
// result selection, quotient saturation and the output register
// depends on cau_pkg
`default_nettype none
module cau_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 en,
   input  wire                 in_valid,
   input  cau_pkg::stage_type  in_stage,
   output logic                out_valid,
   output logic [31:0]         out_re,
   output logic [31:0]         out_im,
   output logic                out_ovf,
   output logic                out_dz
);

   logic        valid_ff;
   logic [31:0] re_ff, im_ff, re_in, im_in;
   logic        ovf_ff, dz_ff, ovf_in, dz_in;
   logic [32:0] qr, qi;

   always_comb begin
      qr = cau_pkg::quo_sat(in_stage.re);
      qi = cau_pkg::quo_sat(in_stage.im);
      dz_in = 1'b0;
      if (in_stage.action != cau_pkg::ACT_DIV) begin
         re_in  = in_stage.fast_re;
         im_in  = in_stage.fast_im;
         ovf_in = in_stage.fast_ovf;
      end else if (in_stage.div_zero) begin
         re_in  = '0;
         im_in  = '0;
         ovf_in = 1'b0;
         dz_in  = 1'b1;
      end else begin
         re_in  = qr[31:0];
         im_in  = qi[31:0];
         ovf_in = qr[32] | qi[32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         re_ff  <= re_in;
         im_ff  <= im_in;
         ovf_ff <= ovf_in;
         dz_ff  <= dz_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_re    = re_ff;
   assign out_im    = im_ff;
   assign out_ovf   = ovf_ff;
   assign out_dz    = dz_ff;

endmodule
`default_nettype wire

>>> hdl/complex_arithmetic_unit.sv
// Complex add, subtract, multiply and divide on signed fixed-point operands with
// saturated results. Fully pipelined: one transaction per cycle unless stalled, and
// every action passes through the same registers (four setup stages with the products,
// a chain of 33 divider cells giving one quotient bit each, and the output register).
// The whole pipeline holds while a result waits on rsp_tready.
// depends on cau_pkg, cau_front, cau_div_cell, cau_back
`default_nettype none
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = 16
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [127:0] req_tdata,  // lhs_real, lhs_imag, rhs_real, rhs_imag
   input  wire  [1:0]   req_tuser,  // action
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [63:0]  rsp_tdata,  // res_real, res_imag
   output logic [1:0]   rsp_tuser   // overflow, div_zero
);

   logic en;
   logic               chain_valid [0:cau_pkg::CELLS];
   cau_pkg::stage_type chain_stage [0:cau_pkg::CELLS];
   logic [31:0] re, im;
   logic        ovf, dz;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_action (req_tuser),
      .in_a      (req_tdata[31:0]),
      .in_b      (req_tdata[63:32]),
      .in_c      (req_tdata[95:64]),
      .in_d      (req_tdata[127:96]),
      .out_valid (chain_valid[0]),
      .out_stage (chain_stage[0])
   );

   for (genvar i = 0; i < cau_pkg::CELLS; i++) begin : g_cell
      cau_div_cell #(.SHIFT(cau_pkg::CELLS - 1 - i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_valid[i]),
         .in_stage  (chain_stage[i]),
         .out_valid (chain_valid[i+1]),
         .out_stage (chain_stage[i+1])
      );
   end

   cau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (chain_valid[cau_pkg::CELLS]),
      .in_stage  (chain_stage[cau_pkg::CELLS]),
      .out_valid (rsp_tvalid),
      .out_re    (re),
      .out_im    (im),
      .out_ovf   (ovf),
      .out_dz    (dz)
   );

   assign rsp_tdata = {im, re};
   assign rsp_tuser = {dz, ovf};

endmodule
`default_nettype wire

>>> hdl/cau_checker.sv
// port-level checks for the complex arithmetic unit, bound to the top level
// depends on complex_arithmetic_unit
`default_nettype none
module cau_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire [127:0] req_tdata,
   input wire [1:0]   req_tuser,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [63:0]  rsp_tdata,
   input wire [1:0]   rsp_tuser
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output stall");

   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && rsp_tdata == 64'd0)
      else $error("zero divisor result not clean");

   a_rst: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
`default_nettype wire
